// ----- hw/rtl/arith_number_tokenizer_unit_macros.svh -----
// Assertion macros used by the tokenizer top level.
`ifndef ARITH_NUMBER_TOKENIZER_UNIT_MACROS_SVH
`define ARITH_NUMBER_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ANTOK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");
// Next-cycle implication.
`define ANTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");
`else
`define ANTOK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ANTOK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/antok_pkg.sv -----
// Package with types, constants and helpers for the number tokenizer.
package antok_pkg;

   localparam int OFFSET_WIDTH    = 32;
   localparam int LENGTH_WIDTH    = 8;
   localparam int QUEUE_DEPTH     = 4;   // power of two, at least 2
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_PLUS    = 3'd0;
   localparam logic [2:0] KIND_MINUS   = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd2;
   localparam logic [2:0] KIND_END     = 3'd3;
   localparam logic [2:0] KIND_INVALID = 3'd4;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_E_LOWER = 8'h65;
   localparam logic [7:0] CH_E_UPPER = 8'h45;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;

   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_INT     = 3'd1,
      S_INTDOT  = 3'd2,
      S_LEADDOT = 3'd3,
      S_FRAC    = 3'd4,
      S_EXP     = 3'd5,
      S_EXPSGN  = 3'd6,
      S_EXPINT  = 3'd7
   } scan_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [2:0]  tok_kind;
      logic [31:0] tok_start;
      logic [7:0]  tok_len;
      logic        malformed;
      logic        last;
   } rsp_type;

   // Up to two tokens from one byte; a flushed number always comes first.
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } emit_type;

   typedef struct packed {
      logic [QUEUE_CNT_WIDTH-1:0] count;
      logic                       room;
   } queue_status_type;

   function automatic logic [31:0] to_start(input logic [OFFSET_WIDTH-1:0] x);
      logic [63:0] t;
      t = 64'(x);
      return t[31:0];
   endfunction

   function automatic logic [7:0] to_len(input logic [LENGTH_WIDTH-1:0] x);
      logic [63:0] t;
      t = 64'(x);
      return t[7:0];
   endfunction

endpackage

// ----- hw/rtl/antok_scan.sv -----
// Scanner: number DFA, token formation, byte offset and halt state.
module antok_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  antok_pkg::req_type  in_item,
   output antok_pkg::emit_type emit
);
   import antok_pkg::*;

   scan_state_type            state_ff, state_in;
   logic [OFFSET_WIDTH-1:0]   start_ff, start_in;
   logic [LENGTH_WIDTH-1:0]   len_ff, len_in;
   logic [OFFSET_WIDTH-1:0]   offset_ff, offset_in;
   logic                      halted_ff, halted_in;

   logic [7:0]      ch;
   logic            is_digit, is_ws, is_sign, is_exp, is_dot;
   scan_state_type  adv_state;
   logic            active, extend, flush, fresh, go, go_byte, go_end;
   logic            mal;

   assign ch       = in_item.ch;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_exp   = (ch == CH_E_LOWER) || (ch == CH_E_UPPER);
   assign is_dot   = (ch == CH_DOT);

   always_comb begin
      case (state_ff)
         S_INT:              adv_state = is_digit ? S_INT : is_dot ? S_INTDOT :
                                         is_exp ? S_EXP : S_IDLE;
         S_INTDOT, S_FRAC:   adv_state = is_digit ? S_FRAC : is_exp ? S_EXP : S_IDLE;
         S_LEADDOT:          adv_state = is_digit ? S_FRAC : S_IDLE;
         S_EXP:              adv_state = is_sign ? S_EXPSGN : is_digit ? S_EXPINT : S_IDLE;
         S_EXPSGN, S_EXPINT: adv_state = is_digit ? S_EXPINT : S_IDLE;
         default:            adv_state = S_IDLE;
      endcase
   end

   assign go      = in_accept && !halted_ff;
   assign go_end  = go && in_item.end_mark;
   assign go_byte = go && !in_item.end_mark;
   assign active  = (state_ff != S_IDLE);
   assign extend  = active && (adv_state != S_IDLE);
   assign flush   = active && (go_end || (go_byte && !extend));
   assign fresh   = go_byte && !extend;
   assign mal     = (state_ff == S_LEADDOT) || (state_ff == S_EXP) || (state_ff == S_EXPSGN);

   // Next state
   always_comb begin
      state_in  = state_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      offset_in = offset_ff;
      halted_in = halted_ff;
      if (flush) begin
         state_in = S_IDLE;
         start_in = '0;
         len_in   = '0;
      end
      if (go_byte) begin
         offset_in = offset_ff + OFFSET_WIDTH'(1);
         if (extend) begin
            state_in = adv_state;
            if (len_ff != '1) begin
               len_in = len_ff + LENGTH_WIDTH'(1);
            end
         end else if (is_digit || is_dot) begin
            state_in = is_digit ? S_INT : S_LEADDOT;
            start_in = offset_ff;
            len_in   = LENGTH_WIDTH'(1);
         end else if (!is_ws && !is_sign) begin
            halted_in = 1'b1;
         end
      end
   end

   // Outputs
   rsp_type num_tok, oth_tok;
   logic    oth_valid;

   always_comb begin
      oth_tok.tok_start = to_start(offset_ff);
      oth_tok.malformed = 1'b0;
      oth_tok.last      = 1'b1;
      oth_tok.tok_len   = 8'd1;
      oth_valid         = 1'b0;
      if (go_end) begin
         oth_tok.tok_kind = KIND_END;
         oth_tok.tok_len  = 8'd0;
         oth_valid        = 1'b1;
      end else if (is_sign) begin
         oth_tok.tok_kind = (ch == CH_PLUS) ? KIND_PLUS : KIND_MINUS;
         oth_valid        = fresh;
      end else begin
         oth_tok.tok_kind = KIND_INVALID;
         oth_valid        = fresh && !is_ws && !is_digit && !is_dot;
      end

      num_tok.tok_kind  = KIND_NUMBER;
      num_tok.tok_start = to_start(start_ff);
      num_tok.tok_len   = to_len(len_ff);
      num_tok.malformed = mal;
      num_tok.last      = !oth_valid;

      emit.first_valid  = flush || oth_valid;
      emit.second_valid = flush && oth_valid;
      emit.first        = flush ? num_tok : oth_tok;
      emit.second       = oth_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         start_ff  <= '0;
         len_ff    <= '0;
         offset_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         offset_ff <= offset_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ----- hw/rtl/antok_queue.sv -----
// Result queue: takes up to two tokens a cycle, hands out one per transfer.
module antok_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  antok_pkg::emit_type         emit,
   output antok_pkg::queue_status_type status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output antok_pkg::rsp_type          rsp_payload
);
   import antok_pkg::*;

   rsp_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       pop;
   logic [QUEUE_CNT_WIDTH-1:0] adds;

   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign adds        = QUEUE_CNT_WIDTH'(emit.first_valid) +
                        QUEUE_CNT_WIDTH'(emit.second_valid);

   assign status.count = count_ff;
   assign status.room  = (count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(adds);
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + adds - QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (emit.first_valid) begin
         entry_ff[wr_ptr_ff] <= emit.first;
      end
      if (emit.second_valid) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_WIDTH'(1)] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/arith_number_tokenizer_unit.sv -----
// Top level of the streaming number tokenizer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  req     | in  | req_valid/req_stall | ch, end_mark (one byte or end mark)
//  rsp     | out | rsp_valid/rsp_stall | tok_kind, tok_start, tok_len,
//          |     |                     | malformed, last
//
//  One byte is taken per cycle while req_stall is low: the scanner makes a
//  single DFA transition per transfer and writes zero, one or two tokens
//  into a four-entry queue; req_stall rises only while the queue holds more
//  than two tokens, so a consumer that takes a token every cycle never slows
//  the byte stream. With the queue empty, the first token of a byte is on rsp
//  the cycle after its transfer; a second token follows once the first is taken.
//  Reset clears the scanner, the byte offset, the halt flag and the queue.
//  After an invalid byte, bytes are still taken but dropped until reset.
module arith_number_tokenizer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  antok_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output antok_pkg::rsp_type rsp_payload
);
   import antok_pkg::*;

`include "arith_number_tokenizer_unit_macros.svh"

   emit_type         emit;
   queue_status_type status;
   logic             req_accept;

   // Hold bytes back until the queue can absorb a two-token burst.
   assign req_stall  = !status.room;
   assign req_accept = req_valid && !req_stall;

   antok_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_item   (req_payload),
      .emit      (emit)
   );

   antok_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .emit        (emit),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A second token in one cycle only follows a flushed number.
   `ANTOK_ASSERT_IMPLY(a_second_after_number, clock, reset, emit.second_valid,
      emit.first_valid && emit.first.tok_kind == KIND_NUMBER)
   // After any token is written, rsp_valid is high in the next cycle.
   `ANTOK_ASSERT_NEXT(a_token_visible, clock, reset, emit.first_valid, rsp_valid)
   // The queue never holds more than its depth.
   `ANTOK_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1,
      status.count <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))

endmodule

// ----- tb/arith_number_tokenizer_unit_tb.sv -----
// Self-checking testbench for the streaming number tokenizer.
module arith_number_tokenizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import antok_pkg::*;

   localparam int PERIOD           = 10;
   localparam int RANDOM_PER_PHASE = 400;
   localparam int DRAIN_CYCLES     = 16;
   localparam int LIMIT_CYCLES     = 400000;
   // Idle percentages per phase: none, sender only, receiver only, both.
   localparam int GAP_PCT [4]   = '{0, 53, 0, 23};
   localparam int STALL_PCT [4] = '{0, 0, 53, 23};

   typedef struct {
      req_type item;
      bit      typed;   // want holds the single token this byte must give
      rsp_type want;
   } step_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int          gap_pct    = 0;
   int          stall_pct  = 0;
   int          mismatches = 0;
   int          items_sent = 0;
   int unsigned cycles     = 0;

   // Tokens still owed by the block, oldest first.
   rsp_type      tokens_due [$];
   step_row_type opening [$];
   step_row_type closing [$];

   // Lexer state as the block should hold it.
   scan_state_type scan_m    = S_IDLE;
   logic [31:0]    num_start = '0;
   logic [7:0]     num_len   = '0;
   logic [31:0]    byte_pos  = '0;
   bit             halted_m  = 1'b0;

   arith_number_tokenizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- lexer

   function automatic bit is_numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   // Next number state, or idle when the byte cannot extend the number.
   function automatic scan_state_type step_scan(scan_state_type s, logic [7:0] c);
      bit             d;
      bit             e;
      scan_state_type nx;
      d  = is_numeral(c);
      e  = (c == CH_E_LOWER) || (c == CH_E_UPPER);
      nx = S_IDLE;
      case (s)
         S_INT: begin
            if (d) nx = S_INT;
            else if (c == CH_DOT) nx = S_INTDOT;
            else if (e) nx = S_EXP;
         end
         S_INTDOT, S_FRAC: begin
            if (d) nx = S_FRAC;
            else if (e) nx = S_EXP;
         end
         S_LEADDOT: begin
            if (d) nx = S_FRAC;
         end
         S_EXP: begin
            if (c == CH_PLUS || c == CH_MINUS) nx = S_EXPSGN;
            else if (d) nx = S_EXPINT;
         end
         S_EXPSGN, S_EXPINT: begin
            if (d) nx = S_EXPINT;
         end
         default: nx = S_IDLE;
      endcase
      return nx;
   endfunction

   function automatic rsp_type make_tok(logic [2:0] kind, logic [31:0] start,
                                        logic [7:0] len, logic mal);
      rsp_type t;
      t.tok_kind  = kind;
      t.tok_start = start;
      t.tok_len   = len;
      t.malformed = mal;
      t.last      = 1'b0;
      return t;
   endfunction

   // Emit the pending number and drop back to idle.
   function automatic rsp_type close_number();
      rsp_type t;
      t = make_tok(KIND_NUMBER, num_start, num_len,
                   scan_m inside {S_LEADDOT, S_EXP, S_EXPSGN});
      scan_m    = S_IDLE;
      num_start = '0;
      num_len   = '0;
      return t;
   endfunction

   // Advance the lexer by one accepted transfer; return the token count.
   function automatic int predict_tokens(input req_type r, output rsp_type made [2]);
      int             n;
      scan_state_type nx;
      n       = 0;
      made[0] = '0;
      made[1] = '0;
      if (halted_m) return 0;
      if (r.end_mark) begin
         // flush the number, then end of input; the offset holds
         if (scan_m != S_IDLE) begin
            made[n] = close_number();
            n++;
         end
         made[n] = make_tok(KIND_END, byte_pos, 8'd0, 1'b0);
         n++;
      end else begin
         if (scan_m != S_IDLE) begin
            nx = step_scan(scan_m, r.ch);
            if (nx != S_IDLE) begin
               scan_m = nx;
               if (num_len != 8'hFF) num_len++;
            end else begin
               made[n] = close_number();
               n++;
            end
         end
         // a byte that ended a number is scanned again from idle
         if (scan_m == S_IDLE) begin
            if (r.ch == CH_PLUS || r.ch == CH_MINUS) begin
               made[n] = make_tok(r.ch == CH_PLUS ? KIND_PLUS : KIND_MINUS,
                                  byte_pos, 8'd1, 1'b0);
               n++;
            end else if (is_numeral(r.ch) || r.ch == CH_DOT) begin
               scan_m    = is_numeral(r.ch) ? S_INT : S_LEADDOT;
               num_start = byte_pos;
               num_len   = 8'd1;
            end else if (!is_blank(r.ch)) begin
               made[n] = make_tok(KIND_INVALID, byte_pos, 8'd1, 1'b0);
               n++;
               halted_m = 1'b1;
            end
         end
         byte_pos++;
      end
      if (n > 0) made[n-1].last = 1'b1;
      return n;
   endfunction

   // -------------------------------------------------------------- stimulus

   function automatic step_row_type plain_row(logic [7:0] ch, bit mark);
      step_row_type r;
      r.item.ch       = ch;
      r.item.end_mark = mark;
      r.typed         = 1'b0;
      r.want          = '0;
      return r;
   endfunction

   function automatic step_row_type typed_row(logic [7:0] ch, bit mark, logic [2:0] kind,
                                              logic [31:0] start, logic [7:0] len);
      step_row_type r;
      r       = plain_row(ch, mark);
      r.typed = 1'b1;
      r.want  = make_tok(kind, start, len, 1'b0);
      r.want.last = 1'b1;
      return r;
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'(CH_ZERO + $urandom_range(9));
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] exp_letter();
      return $urandom_range(1) ? CH_E_UPPER : CH_E_LOWER;
   endfunction

   function automatic logic [7:0] sign_byte();
      return $urandom_range(1) ? CH_MINUS : CH_PLUS;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(7))
         0:       return blank_byte();
         1:       return CH_PLUS;
         2:       return CH_MINUS;
         3:       return CH_DOT;
         4:       return CH_E_LOWER;
         5:       return CH_E_UPPER;
         default: return any_digit();
      endcase
   endfunction

   // Hold the item until the block takes it, then book the tokens it owes.
   task automatic transfer(input req_type item, input bit typed, input rsp_type want);
      rsp_type made [2];
      int      n;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      n = predict_tokens(item, made);
      if (typed) tokens_due.push_back(want);
      else for (int i = 0; i < n; i++) tokens_due.push_back(made[i]);
      items_sent++;
   endtask

   // An exponent letter that the current number cannot take would halt the block
   // for the rest of the run, so swap it for a digit there.
   task automatic send_char(logic [7:0] c);
      req_type item;
      if ((c == CH_E_LOWER || c == CH_E_UPPER) && !(scan_m inside {S_INT, S_INTDOT, S_FRAC}))
         c = any_digit();
      item.ch       = c;
      item.end_mark = 1'b0;
      transfer(item, 1'b0, '0);
   endtask

   // End marker with a random byte beside it; the byte must be ignored.
   task automatic send_mark();
      req_type item;
      item.ch       = 8'($urandom_range(255));
      item.end_mark = 1'b1;
      transfer(item, 1'b0, '0);
   endtask

   task automatic send_digits(int n);
      repeat (n) send_char(any_digit());
   endtask

   task automatic send_separator();
      case ($urandom_range(5))
         0, 1:    send_char(blank_byte());
         2:       send_char(CH_PLUS);
         3:       send_char(CH_MINUS);
         4:       send_mark();
         default: ;   // run straight into the next sequence
      endcase
   endtask

   task automatic send_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         // well-formed literal, optional exponent
         case ($urandom_range(2))
            0: send_digits($urandom_range(1, 4));
            1: begin
               send_digits($urandom_range(1, 3));
               send_char(CH_DOT);
               send_digits($urandom_range(0, 3));
            end
            default: begin
               send_char(CH_DOT);
               send_digits($urandom_range(1, 3));
            end
         endcase
         if ($urandom_range(1)) begin
            send_char(exp_letter());
            if ($urandom_range(1)) send_char(sign_byte());
            send_digits($urandom_range(1, 3));
         end
         send_separator();
      end else if (pick < 75) begin
         // literal cut short: lone dot, or exponent with no digits
         case ($urandom_range(2))
            0: send_char(CH_DOT);
            1: begin
               send_digits($urandom_range(1, 3));
               send_char(exp_letter());
            end
            default: begin
               send_digits($urandom_range(1, 2));
               send_char(exp_letter());
               send_char(sign_byte());
            end
         endcase
         send_separator();
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 6)) send_char(noise_byte());
      end else begin
         send_mark();
      end
   endtask

   // Drop valid and hold until the block owes nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------ checking

   task automatic report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_tokens
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            mismatches++;
            $display("%0t: token with none due, expected nothing, got kind %0d start %0d len %0d",
                     $time, rsp_payload.tok_kind, rsp_payload.tok_start, rsp_payload.tok_len);
         end else begin
            want = tokens_due.pop_front();
            if (rsp_payload.tok_kind !== want.tok_kind)
               report_field("tok_kind", 32'(want.tok_kind), 32'(rsp_payload.tok_kind));
            if (rsp_payload.tok_start !== want.tok_start)
               report_field("tok_start", want.tok_start, rsp_payload.tok_start);
            if (rsp_payload.tok_len !== want.tok_len)
               report_field("tok_len", 32'(want.tok_len), 32'(rsp_payload.tok_len));
            if (rsp_payload.malformed !== want.malformed)
               report_field("malformed", 32'(want.malformed), 32'(rsp_payload.malformed));
            if (rsp_payload.last !== want.last)
               report_field("last", 32'(want.last), 32'(rsp_payload.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- run

   initial begin
      // Offsets in the comments are the byte offset each row lands on.
      opening = '{
         typed_row(8'hA5, 1'b1, KIND_END, 32'd0, 8'd0),   // end right after reset
         typed_row(CH_PLUS, 1'b0, KIND_PLUS, 32'd0, 8'd1),
         typed_row(CH_MINUS, 1'b0, KIND_MINUS, 32'd1, 8'd1),
         plain_row(CH_SPACE, 1'b0),
         plain_row(CH_TAB, 1'b0),
         plain_row(CH_CR, 1'b0),
         plain_row(CH_LF, 1'b0),
         plain_row(CH_ZERO, 1'b0),                        // 0.9e+5 from offset 6
         plain_row(CH_DOT, 1'b0),
         plain_row(CH_NINE, 1'b0),
         plain_row(CH_E_LOWER, 1'b0),
         plain_row(CH_PLUS, 1'b0),
         plain_row(8'(CH_ZERO + 5), 1'b0),
         plain_row(CH_MINUS, 1'b0),                       // number, then minus
         plain_row(CH_DOT, 1'b0),                         // lone dot ...
         plain_row(8'h5A, 1'b1),                          // ... flushed malformed by end
         plain_row(8'(CH_ZERO + 7), 1'b0),
         plain_row(CH_E_UPPER, 1'b0),
         plain_row(CH_SPACE, 1'b0),                       // exponent with no digits
         plain_row(8'(CH_ZERO + 8), 1'b0),
         plain_row(CH_DOT, 1'b0),
         plain_row(CH_E_LOWER, 1'b0),
         plain_row(CH_MINUS, 1'b0),
         plain_row(8'hFF, 1'b1),                          // end after exponent sign
         plain_row(8'(CH_ZERO + 3), 1'b0)
      };
      // Invalid bytes halt the block until reset, so they only close the run.
      closing = '{
         plain_row(8'(CH_ZERO + 4), 1'b0),
         plain_row(8'hFF, 1'b0),                          // number, then invalid
         plain_row(8'h00, 1'b1),                          // dropped while halted
         plain_row(8'(CH_ZERO + 2), 1'b0),
         plain_row(8'h80, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) transfer(opening[i].item, opening[i].typed, opening[i].want);

      for (int p = 0; p < 4; p++) begin
         // hold the sender until every owed token is out
         wait_drained();
         gap_pct   = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         // overrun the length counter so it has to saturate
         if (p % 2 == 1) begin
            send_digits($urandom_range(256, 300));
            send_char(CH_SPACE);
         end
         while (items_sent < opening.size() + (p + 1) * RANDOM_PER_PHASE) send_sequence();
      end

      gap_pct   = 23;
      stall_pct = 23;
      foreach (closing[i]) transfer(closing[i].item, closing[i].typed, closing[i].want);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
